// ===== rtl/core/mbd_pkg.sv =====
// Shared types and constants for the 2x2 box mipmap downsampler.
// Used by mbd_ctrl, mbd_out and the top level under rtl/core; depends on nothing.
package mbd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);

  localparam int CHAN_W  = 8;
  localparam int LANE_W  = CHAN_W + 1;
  localparam int SWIDTH_W  = 12;
  localparam int SHEIGHT_W = 16;
  localparam int ROW_W   = SHEIGHT_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int MIN_DIM = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  // Four 9-bit lanes holding red, green, blue and alpha or their pair sums.
  typedef struct packed {
    logic [LANE_W-1:0] alpha;
    logic [LANE_W-1:0] blue;
    logic [LANE_W-1:0] green;
    logic [LANE_W-1:0] red;
  } lanes_t;

  localparam int LANES_W = $bits(lanes_t);

  // Line store access issued at the input transfer.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    lanes_t            wdata;
  } ram_req_t;

  // Item handed from the front end to the result stage.
  typedef struct packed {
    logic   load;
    logic   last;
    lanes_t pair;
  } item_t;

endpackage

// ===== rtl/core/mbd_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // The read data holds until the next read so a stalled result keeps it.
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mbd_ctrl.sv =====
// Front end: configuration registers, column and row counters, pair hold,
// pair sums and line store requests. Depends on mbd_pkg.
module mbd_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [mbd_pkg::CHAN_W-1:0]      red,
  input  logic [mbd_pkg::CHAN_W-1:0]      green,
  input  logic [mbd_pkg::CHAN_W-1:0]      blue,
  input  logic [mbd_pkg::CHAN_W-1:0]      alpha,
  output mbd_pkg::ram_req_t               ram_req,
  output mbd_pkg::item_t                  item
);

  localparam logic [mbd_pkg::SWIDTH_W-1:0] W_CLIP = mbd_pkg::SWIDTH_W'(mbd_pkg::MAX_WIDTH);

  logic [mbd_pkg::SWIDTH_W-1:0]  width_r;
  logic [mbd_pkg::SHEIGHT_W-1:0] height_r;
  logic [mbd_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [mbd_pkg::ROW_W-1:0]     row_r, row_nxt;
  mbd_pkg::lanes_t               hold_r;

  logic [mbd_pkg::SWIDTH_W-1:0]  eff_w;
  logic [mbd_pkg::SWIDTH_W-1:0]  col_inc;
  logic [mbd_pkg::ROW_W:0]       row_inc;
  logic [mbd_pkg::SWIDTH_W-1:0]  last_col;
  logic [mbd_pkg::ROW_W-1:0]     last_row;
  logic                          big_enough;
  logic                          odd_col;
  logic                          odd_row;
  mbd_pkg::lanes_t               pix;
  mbd_pkg::lanes_t               pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mbd_pkg::REG_SRC_WIDTH) begin
        width_r <= cfg_data[mbd_pkg::SWIDTH_W-1:0];
      end else if (cfg_index == mbd_pkg::REG_SRC_HEIGHT) begin
        height_r <= cfg_data[mbd_pkg::SHEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    eff_w      = (width_r > W_CLIP) ? W_CLIP : width_r;
    col_inc    = mbd_pkg::SWIDTH_W'(col_r) + mbd_pkg::SWIDTH_W'(1);
    row_inc    = {1'b0, row_r} + (mbd_pkg::ROW_W + 1)'(1);
    last_col   = {eff_w[mbd_pkg::SWIDTH_W-1:1], 1'b0} - mbd_pkg::SWIDTH_W'(1);
    last_row   = {height_r[mbd_pkg::SHEIGHT_W-1:1], 1'b0} - mbd_pkg::ROW_W'(1);
    big_enough = (eff_w > mbd_pkg::SWIDTH_W'(mbd_pkg::MIN_DIM)) &&
                 (height_r > mbd_pkg::SHEIGHT_W'(mbd_pkg::MIN_DIM));
    odd_col    = col_r[0];
    odd_row    = row_r[0];

    pix.red   = {1'b0, red};
    pix.green = {1'b0, green};
    pix.blue  = {1'b0, blue};
    pix.alpha = {1'b0, alpha};
    pair.red   = hold_r.red   + pix.red;
    pair.green = hold_r.green + pix.green;
    pair.blue  = hold_r.blue  + pix.blue;
    pair.alpha = hold_r.alpha + pix.alpha;

    // Counters wrap at the bound; a zero bound wraps on every pixel.
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, height_r}) ? '0 : row_inc[mbd_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[mbd_pkg::COL_W-1:0];
      row_nxt = row_r;
    end

    // Even rows store pair sums; odd rows read them back for the block total.
    ram_req.we    = accept && odd_col && !odd_row;
    ram_req.re    = accept && odd_col && odd_row && big_enough;
    ram_req.addr  = col_r[mbd_pkg::COL_W-1:1];
    ram_req.wdata = pair;

    item.load = ram_req.re;
    item.last = (mbd_pkg::SWIDTH_W'(col_r) == last_col) && (row_r == last_row);
    item.pair = pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!odd_col) begin
        hold_r <= pix;
      end
    end
  end

endmodule

// ===== rtl/core/mbd_out.sv =====
// Result side: holds a pending block pair sum while the line store read lands,
// then adds the stored sums, divides by four and presents the result register.
// Depends on mbd_pkg.
module mbd_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbd_pkg::item_t              item,
  input  mbd_pkg::lanes_t             above,
  input  logic                        out_stall,
  output logic                        busy,
  output logic                        out_valid,
  output logic [mbd_pkg::CHAN_W-1:0]  red,
  output logic [mbd_pkg::CHAN_W-1:0]  green,
  output logic [mbd_pkg::CHAN_W-1:0]  blue,
  output logic [mbd_pkg::CHAN_W-1:0]  alpha,
  output logic                        last
);

  logic                       s1_valid_r;
  logic                       s1_last_r;
  mbd_pkg::lanes_t            s1_pair_r;
  logic                       out_valid_r;
  logic                       last_r;
  logic [mbd_pkg::CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic [mbd_pkg::CHAN_W-1:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic [mbd_pkg::LANE_W:0]   sum_r, sum_g, sum_b, sum_a;
  logic                       out_free;
  logic                       advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  // A new input would overwrite the held line store read data.
  assign busy     = s1_valid_r && !out_free;

  always_comb begin
    sum_r = {1'b0, above.red}   + {1'b0, s1_pair_r.red};
    sum_g = {1'b0, above.green} + {1'b0, s1_pair_r.green};
    sum_b = {1'b0, above.blue}  + {1'b0, s1_pair_r.blue};
    sum_a = {1'b0, above.alpha} + {1'b0, s1_pair_r.alpha};
    red_nxt   = sum_r[mbd_pkg::LANE_W:2];
    green_nxt = sum_g[mbd_pkg::LANE_W:2];
    blue_nxt  = sum_b[mbd_pkg::LANE_W:2];
    alpha_nxt = sum_a[mbd_pkg::LANE_W:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item.load) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.load) begin
      s1_pair_r <= item.pair;
      s1_last_r <= item.last;
    end
    if (advance) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      last_r  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha     = alpha_r;
  assign last      = last_r;

endmodule

// ===== rtl/core/mipmap_box_downsample_top.sv =====
// Top level of the 2x2 box mipmap downsampler.
// Depends on mbd_pkg, mbd_ctrl, mbd_ram and mbd_out.
//
// Usage:
//   Program src_width (index 0) and src_height (index 1) through the cfg_
//   write channel while the block is idle; cfg_ready is always high.
//   Then send RGBA8 source pixels in raster order on the in_ channel, one
//   transfer per pixel. For every 2x2 block the out_ channel carries one
//   pixel whose channels are the four-pixel sum shifted right by two;
//   out_last_of_level marks the final pixel of the level. An odd last column
//   or row is dropped, and no result is made if the smaller dimension is 16
//   or less.
//   Throughput is one pixel per cycle while in_stall is low: each pixel makes
//   at most one access to the 1024-entry line store of pair sums. The pixel
//   that completes a block goes to the read stage, then to the output register.
//   When the receiver stalls, one result waits in the output register and a
//   second in the read stage; further pixels are then held off by in_stall.
//   Reset clears the configuration registers, counters and pipeline valids; the line store
//   needs no clearing pass, as each entry is written on an even row before
//   the odd row reads it.
module mipmap_box_downsample_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mbd_pkg::CHAN_W-1:0]      in_red_in,
  input  logic [mbd_pkg::CHAN_W-1:0]      in_green_in,
  input  logic [mbd_pkg::CHAN_W-1:0]      in_blue_in,
  input  logic [mbd_pkg::CHAN_W-1:0]      in_alpha_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mbd_pkg::CHAN_W-1:0]      out_red_out,
  output logic [mbd_pkg::CHAN_W-1:0]      out_green_out,
  output logic [mbd_pkg::CHAN_W-1:0]      out_blue_out,
  output logic [mbd_pkg::CHAN_W-1:0]      out_alpha_out,
  output logic                            out_last_of_level
);

  logic                     accept;
  logic                     busy;
  mbd_pkg::ram_req_t        ram_req;
  mbd_pkg::item_t           item;
  logic [mbd_pkg::LANES_W-1:0] rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  mbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .red       (in_red_in),
    .green     (in_green_in),
    .blue      (in_blue_in),
    .alpha     (in_alpha_in),
    .ram_req   (ram_req),
    .item      (item)
  );

  mbd_ram #(
    .WIDTH (mbd_pkg::LANES_W),
    .DEPTH (mbd_pkg::STORE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (rdata)
  );

  mbd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .above     (mbd_pkg::lanes_t'(rdata)),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .red       (out_red_out),
    .green     (out_green_out),
    .blue      (out_blue_out),
    .alpha     (out_alpha_out),
    .last      (out_last_of_level)
  );

endmodule
